// ----- hw/rtl/eft_pkg.sv -----
// ----------------------------------------------------------------------------
// eft_pkg
// Shared types, command and status records, and constants for the multipath
// forwarding table.
// ----------------------------------------------------------------------------
package eft_pkg;

    typedef enum logic [1:0] {
        ACT_ADD,
        ACT_REMOVE,
        ACT_LOOKUP,
        ACT_FLUSH
    } act_t;

    typedef enum logic [1:0] {
        RES_OK,
        RES_BAD_ARG,
        RES_NO_MATCH,
        RES_FULL
    } res_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_AGE_RD,
        S_AGE_WR,
        S_NEW,
        S_PSCAN,
        S_PDECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_CNT_WR,
        S_FREE,
        S_CRC,
        S_DIV_INIT,
        S_DIV,
        S_PORT_RD,
        S_PORT_WAIT,
        S_FLUSH,
        S_RESP
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_DECIDE,
        OP_AGE_RD,
        OP_AGE_WR,
        OP_NEW,
        OP_PSCAN,
        OP_PDECIDE,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_PUT,
        OP_CNT_WR,
        OP_FREE,
        OP_CRC,
        OP_DIV_INIT,
        OP_DIV,
        OP_PORT_RD,
        OP_PORT_WAIT,
        OP_FLUSH,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t  op;
        res_t res;
    } dp_cmd_t;

    typedef struct packed {
        act_t in_act;
        logic in_dst_zero;
        act_t act;
        logic scan_done;
        logic hit;
        logic free_hit;
        logic best_empty;
        logic age_done;
        logic pscan_done;
        logic pfound;
        logic pcnt_full;
        logic cnt_zero;
        logic shift_end;
        logic crc_done;
        logic div_done;
        logic out_busy;
    } dp_stat_t;

    localparam int          KEY_BYTES  = 20;
    localparam int          QUO_BITS   = 16;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    // Width of one hash region for each possible port count.
    localparam logic [15:0] HASH_SPAN [17] = '{
        16'hFFFF,
        16'(65535 / 1),  16'(65535 / 2),  16'(65535 / 3),  16'(65535 / 4),
        16'(65535 / 5),  16'(65535 / 6),  16'(65535 / 7),  16'(65535 / 8),
        16'(65535 / 9),  16'(65535 / 10), 16'(65535 / 11), 16'(65535 / 12),
        16'(65535 / 13), 16'(65535 / 14), 16'(65535 / 15), 16'(65535 / 16)
    };

    function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/eft_ctrl.sv -----
// ----------------------------------------------------------------------------
// eft_ctrl
// Sequencer of the forwarding table: walks each transaction through its
// scan, update, hash and divide steps and commands the datapath.
// ----------------------------------------------------------------------------
module eft_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  eft_pkg::dp_stat_t stat,
    output eft_pkg::dp_cmd_t  cmd
);
    import eft_pkg::*;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= RES_OK;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.in_act == ACT_FLUSH)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (stat.in_dst_zero)
                    begin
                        state_next = S_RESP;
                        res_next   = RES_BAD_ARG;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                unique case (stat.act)
                    ACT_LOOKUP:
                    begin
                        if (!stat.hit || stat.best_empty)
                        begin
                            state_next = S_RESP;
                            res_next   = RES_NO_MATCH;
                        end
                        else
                        begin
                            state_next = S_CRC;
                        end
                    end
                    ACT_ADD:
                    begin
                        if (stat.hit)
                        begin
                            state_next = S_PSCAN;
                        end
                        else if (stat.free_hit)
                        begin
                            state_next = S_AGE_RD;
                        end
                        else
                        begin
                            state_next = S_RESP;
                            res_next   = RES_FULL;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (stat.hit)
                        begin
                            state_next = S_PSCAN;
                        end
                        else
                        begin
                            state_next = S_RESP;
                            res_next   = RES_NO_MATCH;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                        res_next   = RES_OK;
                    end
                endcase
            end
            S_AGE_RD:
            begin
                if (stat.age_done)
                begin
                    if (stat.act == ACT_ADD)
                    begin
                        state_next = S_NEW;
                    end
                    else
                    begin
                        state_next = S_RESP;
                        res_next   = RES_OK;
                    end
                end
                else
                begin
                    state_next = S_AGE_WR;
                end
            end
            S_AGE_WR:    state_next = S_AGE_RD;
            S_NEW:       state_next = S_PSCAN;
            S_PSCAN:
            begin
                if (stat.pscan_done)
                begin
                    state_next = S_PDECIDE;
                end
            end
            S_PDECIDE:
            begin
                if (stat.act == ACT_ADD)
                begin
                    if (stat.pfound)
                    begin
                        state_next = S_RESP;
                        res_next   = RES_OK;
                    end
                    else if (stat.pcnt_full)
                    begin
                        state_next = S_RESP;
                        res_next   = RES_FULL;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else if (stat.pfound)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_CNT_WR;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.shift_end)
                begin
                    state_next = (stat.act == ACT_ADD) ? S_PUT : S_CNT_WR;
                end
                else
                begin
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:  state_next = S_SHIFT_RD;
            S_PUT:       state_next = S_CNT_WR;
            S_CNT_WR:
            begin
                if (stat.act != ACT_ADD && stat.cnt_zero)
                begin
                    state_next = S_FREE;
                end
                else
                begin
                    state_next = S_RESP;
                    res_next   = RES_OK;
                end
            end
            S_FREE:      state_next = S_AGE_RD;
            S_CRC:
            begin
                if (stat.crc_done)
                begin
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:  state_next = S_DIV;
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_PORT_RD;
                end
            end
            S_PORT_RD:   state_next = S_PORT_WAIT;
            S_PORT_WAIT:
            begin
                state_next = S_RESP;
                res_next   = RES_OK;
            end
            S_FLUSH:
            begin
                state_next = S_RESP;
                res_next   = RES_OK;
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.res  = res_reg;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_LOAD : OP_NONE;
            end
            S_SCAN:      cmd.op = OP_SCAN;
            S_DECIDE:    cmd.op = OP_DECIDE;
            S_AGE_RD:    cmd.op = OP_AGE_RD;
            S_AGE_WR:    cmd.op = OP_AGE_WR;
            S_NEW:       cmd.op = OP_NEW;
            S_PSCAN:     cmd.op = OP_PSCAN;
            S_PDECIDE:   cmd.op = OP_PDECIDE;
            S_SHIFT_RD:  cmd.op = OP_SHIFT_RD;
            S_SHIFT_WR:  cmd.op = OP_SHIFT_WR;
            S_PUT:       cmd.op = OP_PUT;
            S_CNT_WR:    cmd.op = OP_CNT_WR;
            S_FREE:      cmd.op = OP_FREE;
            S_CRC:       cmd.op = OP_CRC;
            S_DIV_INIT:  cmd.op = OP_DIV_INIT;
            S_DIV:       cmd.op = OP_DIV;
            S_PORT_RD:   cmd.op = OP_PORT_RD;
            S_PORT_WAIT: cmd.op = OP_PORT_WAIT;
            S_FLUSH:     cmd.op = OP_FLUSH;
            S_RESP:      cmd.op = stat.out_busy ? OP_NONE : OP_RESULT;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

// ----- hw/rtl/eft_datapath.sv -----
// ----------------------------------------------------------------------------
// eft_datapath
// Entry and port memories, valid bits, scan and port search registers, the
// byte-wide CRC step, the restoring divider and the output register.
// ----------------------------------------------------------------------------
module eft_datapath #(
    parameter int ENTRIES = 16,
    parameter int PORTS   = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  eft_pkg::dp_cmd_t  cmd,
    output eft_pkg::dp_stat_t stat,
    input  logic [1:0]        action,
    input  logic [31:0]       destination,
    input  logic [7:0]        qos_class,
    input  logic [15:0]       port_id,
    input  logic [31:0]       source_address,
    input  logic [30:0]       cep_source,
    input  logic [30:0]       cep_destination,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [15:0]       next_port,
    output logic              table_empty
);
    import eft_pkg::*;

    localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ECW = $clog2(ENTRIES + 1);
    localparam int CW  = $clog2(PORTS + 1);
    localparam int PD  = ENTRIES * PORTS;
    localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
    localparam int BCW = $clog2(KEY_BYTES + 1);
    localparam int DCW = $clog2(QUO_BITS + 1);

    // Stores
    logic [31:0]      ent_dst_mem [ENTRIES];
    logic [7:0]       ent_qos_mem [ENTRIES];
    logic [EW-1:0]    ent_age_mem [ENTRIES];
    logic [CW-1:0]    ent_cnt_mem [ENTRIES];
    logic [15:0]      port_mem    [PD];
    logic [31:0]      ent_dst_q;
    logic [7:0]       ent_qos_q;
    logic [EW-1:0]    ent_age_q;
    logic [CW-1:0]    ent_cnt_q;
    logic [15:0]      port_q;
    logic [ENTRIES-1:0] valid_reg;

    // Transaction fields
    act_t             act_reg;
    logic [31:0]      dst_reg;
    logic [7:0]       qos_reg;
    logic [15:0]      port_reg;
    logic [31:0]      src_reg;
    logic [30:0]      cs_reg;
    logic [30:0]      cd_reg;

    // Search and update state
    logic [ECW-1:0]   ecnt_reg;
    logic             pend_reg;
    logic [EW-1:0]    ri_reg;
    logic [CW-1:0]    rk_reg;
    logic [CW-1:0]    k_reg;
    logic             hit_reg;
    logic             free_hit_reg;
    logic [EW-1:0]    best_idx_reg;
    logic [EW-1:0]    free_idx_reg;
    logic [EW-1:0]    best_age_reg;
    logic [CW-1:0]    best_cnt_reg;
    logic [CW-1:0]    pcnt_reg;
    logic             pfound_reg;
    logic [CW-1:0]    ppos_reg;

    // Hash and divide
    logic [15:0]      crc_reg;
    logic [BCW-1:0]   bcnt_reg;
    logic [15:0]      quo_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      dvs_reg;
    logic [DCW-1:0]   dcnt_reg;
    logic [15:0]      nport_reg;

    // Output register
    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [15:0]      next_port_reg;
    logic             empty_reg;

    logic             scan_match;
    logic             scan_better;
    logic [EW-1:0]    ent_adr;
    logic [EW-1:0]    age_idx;
    logic             age_we;
    logic [CW-1:0]    poff;
    logic [PAW-1:0]   port_adr;
    logic             port_we;
    logic [15:0]      port_wd;
    logic [CW-1:0]    pcnt_m1;
    logic [CW-1:0]    region;
    logic [159:0]     key;
    logic [7:0]       key_byte;
    logic [16:0]      rem_sh;
    logic             is_add;

    assign is_add  = (act_reg == ACT_ADD);
    assign age_idx = ecnt_reg[EW-1:0];

    assign scan_match  = valid_reg[ri_reg] && (ent_dst_q == dst_reg) &&
                         ((ent_qos_q == 8'h00) || (ent_qos_q == qos_reg));
    assign scan_better = !hit_reg || (ent_age_q < best_age_reg);

    // Ages above the freed entry's rank close up; on creation all move up.
    assign age_we = (cmd.op == OP_AGE_WR) && valid_reg[age_idx] &&
                    (is_add || (ent_age_q > best_age_reg));

    assign pcnt_m1 = pcnt_reg - CW'(1);
    assign region  = (quo_reg > 16'(pcnt_m1)) ? pcnt_m1 : quo_reg[CW-1:0];

    assign key      = {1'b0, cd_reg, 1'b0, cs_reg, 24'h000000, qos_reg, dst_reg, src_reg};
    assign key_byte = key[8*bcnt_reg +: 8];
    assign rem_sh   = {rem_reg, quo_reg[15]};

    always_comb
    begin
        case (cmd.op)
            OP_NEW:  ent_adr = free_idx_reg;
            OP_CNT_WR: ent_adr = best_idx_reg;
            default: ent_adr = age_idx;
        endcase
    end

    always_comb
    begin
        port_we = 1'b0;
        port_wd = port_q;
        case (cmd.op)
            OP_SHIFT_RD: poff = is_add ? (k_reg - CW'(1)) : (k_reg + CW'(1));
            OP_PORT_RD:  poff = region;
            OP_PUT:
            begin
                poff    = '0;
                port_we = 1'b1;
                port_wd = port_reg;
            end
            OP_SHIFT_WR:
            begin
                poff    = k_reg;
                port_we = 1'b1;
            end
            default:     poff = k_reg;
        endcase
    end

    assign port_adr = PAW'(best_idx_reg) * PAW'(PORTS) + PAW'(poff);

    // Entry memories: one address per cycle, registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_NEW)
        begin
            ent_dst_mem[ent_adr] <= dst_reg;
            ent_qos_mem[ent_adr] <= qos_reg;
            ent_age_mem[ent_adr] <= '0;
            ent_cnt_mem[ent_adr] <= '0;
        end
        if (cmd.op == OP_CNT_WR)
        begin
            ent_cnt_mem[ent_adr] <= pcnt_reg;
        end
        if (age_we)
        begin
            ent_age_mem[ent_adr] <= is_add ? (ent_age_q + EW'(1)) : (ent_age_q - EW'(1));
        end
        ent_dst_q <= ent_dst_mem[ent_adr];
        ent_qos_q <= ent_qos_mem[ent_adr];
        ent_age_q <= ent_age_mem[ent_adr];
        ent_cnt_q <= ent_cnt_mem[ent_adr];
    end

    always_ff @(posedge clk)
    begin
        if (port_we)
        begin
            port_mem[port_adr] <= port_wd;
        end
        port_q <= port_mem[port_adr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_FLUSH: valid_reg <= '0;
                OP_NEW:   valid_reg[free_idx_reg] <= 1'b1;
                OP_FREE:  valid_reg[best_idx_reg] <= 1'b0;
                default:  ;
            endcase
            if (cmd.op == OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                act_reg      <= act_t'(action);
                dst_reg      <= destination;
                qos_reg      <= qos_class;
                port_reg     <= port_id;
                src_reg      <= source_address;
                cs_reg       <= cep_source;
                cd_reg       <= cep_destination;
                ecnt_reg     <= '0;
                pend_reg     <= 1'b0;
                hit_reg      <= 1'b0;
                free_hit_reg <= 1'b0;
                nport_reg    <= '0;
            end
            OP_SCAN:
            begin
                if (ecnt_reg < ECW'(ENTRIES))
                begin
                    ecnt_reg <= ecnt_reg + ECW'(1);
                    ri_reg   <= ecnt_reg[EW-1:0];
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
                if (pend_reg)
                begin
                    if (scan_match && scan_better)
                    begin
                        hit_reg      <= 1'b1;
                        best_idx_reg <= ri_reg;
                        best_age_reg <= ent_age_q;
                        best_cnt_reg <= ent_cnt_q;
                    end
                    if (!valid_reg[ri_reg] && !free_hit_reg)
                    begin
                        free_hit_reg <= 1'b1;
                        free_idx_reg <= ri_reg;
                    end
                end
            end
            OP_DECIDE:
            begin
                ecnt_reg   <= '0;
                k_reg      <= '0;
                bcnt_reg   <= '0;
                crc_reg    <= '0;
                pfound_reg <= 1'b0;
                pend_reg   <= 1'b0;
                pcnt_reg   <= best_cnt_reg;
            end
            OP_AGE_WR: ecnt_reg <= ecnt_reg + ECW'(1);
            OP_NEW:
            begin
                best_idx_reg <= free_idx_reg;
                best_age_reg <= '0;
                pcnt_reg     <= '0;
                k_reg        <= '0;
            end
            OP_PSCAN:
            begin
                if (!pfound_reg && (k_reg < pcnt_reg))
                begin
                    k_reg    <= k_reg + CW'(1);
                    rk_reg   <= k_reg;
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
                if (pend_reg && !pfound_reg && (port_q == port_reg))
                begin
                    pfound_reg <= 1'b1;
                    ppos_reg   <= rk_reg;
                end
            end
            OP_PDECIDE:
            begin
                if (is_add)
                begin
                    k_reg <= pcnt_reg;
                end
                else if (pfound_reg)
                begin
                    k_reg    <= ppos_reg;
                    pcnt_reg <= pcnt_m1;
                end
            end
            OP_SHIFT_WR: k_reg <= is_add ? (k_reg - CW'(1)) : (k_reg + CW'(1));
            OP_PUT:      pcnt_reg <= pcnt_reg + CW'(1);
            OP_FREE:     ecnt_reg <= '0;
            OP_CRC:
            begin
                // The step stops once all key bytes are in, which raises crc_done and moves
                // the controller on to the divider.
                if (bcnt_reg != BCW'(KEY_BYTES))
                begin
                    crc_reg  <= crc_byte(crc_reg, key_byte);
                    bcnt_reg <= bcnt_reg + BCW'(1);
                end
            end
            OP_DIV_INIT:
            begin
                quo_reg  <= crc_reg;
                rem_reg  <= '0;
                dvs_reg  <= HASH_SPAN[5'(pcnt_reg)];
                dcnt_reg <= '0;
            end
            OP_DIV:
            begin
                if (dcnt_reg != DCW'(QUO_BITS))
                begin
                    if (rem_sh >= {1'b0, dvs_reg})
                    begin
                        rem_reg <= 16'(rem_sh - {1'b0, dvs_reg});
                        quo_reg <= {quo_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[15:0];
                        quo_reg <= {quo_reg[14:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + DCW'(1);
                end
            end
            OP_PORT_WAIT: nport_reg <= port_q;
            OP_RESULT:
            begin
                status_reg    <= cmd.res;
                next_port_reg <= nport_reg;
                empty_reg     <= ~|valid_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        stat.in_act      = act_t'(action);
        stat.in_dst_zero = (destination == 32'h0);
        stat.act         = act_reg;
        stat.scan_done   = (ecnt_reg == ECW'(ENTRIES)) && !pend_reg;
        stat.hit         = hit_reg;
        stat.free_hit    = free_hit_reg;
        stat.best_empty  = (best_cnt_reg == '0);
        stat.age_done    = (ecnt_reg == ECW'(ENTRIES));
        stat.pscan_done  = !pend_reg && (pfound_reg || (k_reg >= pcnt_reg));
        stat.pfound      = pfound_reg;
        stat.pcnt_full   = (pcnt_reg == CW'(PORTS));
        stat.cnt_zero    = (pcnt_reg == '0);
        stat.shift_end   = is_add ? (k_reg == '0) : (k_reg >= pcnt_reg);
        stat.crc_done    = (bcnt_reg == BCW'(KEY_BYTES));
        stat.div_done    = (dcnt_reg == DCW'(QUO_BITS));
        stat.out_busy    = out_valid_reg && !out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign next_port   = next_port_reg;
    assign table_empty = empty_reg;

endmodule

// ----- hw/rtl/ecmp_forwarding_table.sv -----
// ----------------------------------------------------------------------------
// ecmp_forwarding_table
// Sequence: a lookup runs the entry scan, 20 CRC byte steps, 16 divide steps
// and a port read; an add or remove that creates or frees an entry also
// sweeps the ranks of all entries. Any transaction may wait at its end for
// the previous result to be taken.
// Transactions: one at a time, bounded by the scan of the single-port entry
// memory, one entry per cycle, and by the age sweep, a read and a write per entry.
// Reset: asynchronous, clears every valid bit and the output valid flag.
// ----------------------------------------------------------------------------
module ecmp_forwarding_table #(
    parameter int ENTRIES = 16,
    parameter int PORTS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] destination,
    input  logic [7:0]  qos_class,
    input  logic [15:0] port_id,
    input  logic [31:0] source_address,
    input  logic [30:0] cep_source,
    input  logic [30:0] cep_destination,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] next_port,
    output logic        table_empty
);
    import eft_pkg::*;

    // The controller owns the sequence of a transaction; the datapath holds
    // the table, the search registers and the hash and divide units. Each
    // entry carries a rank (0 is the newest), kept dense by sweeping all
    // entries whenever one is created or freed. Among matching entries the
    // one with the lowest rank wins.
    //
    // A lookup hashes the flow key one byte per cycle with the reflected
    // CRC-16 (poly 0xA001, init 0), then divides the hash by the region
    // width for the entry's port count in a restoring divider, one quotient
    // bit per cycle, clamping the region to the last port.
    //
    // The result sits in an output register, so a new transaction can be
    // taken while the previous result still waits to be collected.

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    eft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    eft_datapath #(
        .ENTRIES (ENTRIES),
        .PORTS   (PORTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .action          (action),
        .destination     (destination),
        .qos_class       (qos_class),
        .port_id         (port_id),
        .source_address  (source_address),
        .cep_source      (cep_source),
        .cep_destination (cep_destination),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .next_port       (next_port),
        .table_empty     (table_empty)
    );

    // A new result must never overwrite one that has not been collected.
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.op == OP_RESULT |-> !(out_valid && !out_ready))
        else $error("result written over a pending transaction");

    // Only a successful lookup reports a port.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != RES_OK |-> next_port == 16'h0000)
        else $error("port reported with a failing status");

    // Once a transaction is taken, the block is no longer ready in the cycle after.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("transaction accepted while busy");

endmodule

// ----- test/ecmp_forwarding_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecmp_forwarding_table_checker
// Watches both channels of the forwarding table. It keeps its own copy of the
// table, works out the expected response of every accepted request and
// compares each accepted response with the oldest one outstanding.
// ----------------------------------------------------------------------------
module ecmp_forwarding_table_checker #(
    parameter int ENTRIES = 16,
    parameter int PORTS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] destination,
    input  logic [7:0]  qos_class,
    input  logic [15:0] port_id,
    input  logic [31:0] source_address,
    input  logic [30:0] cep_source,
    input  logic [30:0] cep_destination,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [15:0] next_port,
    input  logic        table_empty,
    output int          fail_count,
    output int          pending_count,
    output int          response_count
);
    import eft_pkg::*;

    typedef struct packed {
        res_t        res;
        logic [15:0] port;
        logic        empty;
    } reply_t;

    reply_t      replies_due[$];
    logic        tbl_valid [ENTRIES];
    logic [31:0] tbl_dst   [ENTRIES];
    logic [7:0]  tbl_qos   [ENTRIES];
    int          tbl_rank  [ENTRIES];
    int          tbl_count [ENTRIES];
    logic [15:0] tbl_ports [ENTRIES][PORTS];

    function automatic int match_entry(logic [31:0] dst, logic [7:0] qos);
        int best;
        best = -1;
        for (int e = 0; e < ENTRIES; e++)
        begin
            if (tbl_valid[e] && tbl_dst[e] == dst && (tbl_qos[e] == 8'd0 || tbl_qos[e] == qos))
            begin
                if (best < 0 || tbl_rank[e] < tbl_rank[best])
                begin
                    best = e;
                end
            end
        end
        return best;
    endfunction

    function automatic logic [15:0] flow_hash(logic [31:0] w [5]);
        logic [15:0] c;
        c = 16'h0000;
        for (int i = 0; i < 5; i++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                c = c ^ {8'h00, w[i][8*b +: 8]};
                for (int k = 0; k < 8; k++)
                begin
                    c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
                end
            end
        end
        return c;
    endfunction

    function automatic res_t table_add(logic [31:0] dst, logic [7:0] qos, logic [15:0] port);
        int idx;
        int slot;
        idx = match_entry(dst, qos);
        if (idx < 0)
        begin
            slot = -1;
            for (int e = ENTRIES - 1; e >= 0; e--)
            begin
                if (!tbl_valid[e])
                begin
                    slot = e;
                end
            end
            if (slot < 0)
            begin
                return RES_FULL;
            end
            for (int e = 0; e < ENTRIES; e++)
            begin
                if (tbl_valid[e])
                begin
                    tbl_rank[e]++;
                end
            end
            idx = slot;
            tbl_valid[idx] = 1'b1;
            tbl_dst[idx]   = dst;
            tbl_qos[idx]   = qos;
            tbl_rank[idx]  = 0;
            tbl_count[idx] = 0;
        end
        for (int k = 0; k < tbl_count[idx]; k++)
        begin
            if (tbl_ports[idx][k] == port)
            begin
                return RES_OK;
            end
        end
        if (tbl_count[idx] >= PORTS)
        begin
            return RES_FULL;
        end
        for (int k = tbl_count[idx]; k > 0; k--)
        begin
            tbl_ports[idx][k] = tbl_ports[idx][k-1];
        end
        tbl_ports[idx][0] = port;
        tbl_count[idx]++;
        return RES_OK;
    endfunction

    function automatic res_t table_remove(logic [31:0] dst, logic [7:0] qos, logic [15:0] port);
        int idx;
        int cnt;
        idx = match_entry(dst, qos);
        if (idx < 0)
        begin
            return RES_NO_MATCH;
        end
        cnt = tbl_count[idx];
        for (int k = 0; k < cnt; k++)
        begin
            if (tbl_ports[idx][k] == port)
            begin
                for (int j = k; j + 1 < cnt; j++)
                begin
                    tbl_ports[idx][j] = tbl_ports[idx][j+1];
                end
                cnt--;
                break;
            end
        end
        tbl_count[idx] = cnt;
        if (cnt == 0)
        begin
            // Freeing an entry closes the gap it leaves in the age ranking.
            for (int e = 0; e < ENTRIES; e++)
            begin
                if (tbl_valid[e] && e != idx && tbl_rank[e] > tbl_rank[idx])
                begin
                    tbl_rank[e]--;
                end
            end
            tbl_valid[idx] = 1'b0;
        end
        return RES_OK;
    endfunction

    function automatic reply_t forward_step();
        reply_t      r;
        int          idx;
        int          region;
        logic [15:0] h;
        logic [31:0] key [5];
        r = '{res: RES_OK, port: 16'h0000, empty: 1'b0};
        if (act_t'(action) == ACT_FLUSH)
        begin
            for (int e = 0; e < ENTRIES; e++)
            begin
                tbl_valid[e] = 1'b0;
                tbl_count[e] = 0;
            end
        end
        else if (destination == 32'd0)
        begin
            r.res = RES_BAD_ARG;
        end
        else if (act_t'(action) == ACT_ADD)
        begin
            r.res = table_add(destination, qos_class, port_id);
        end
        else if (act_t'(action) == ACT_REMOVE)
        begin
            r.res = table_remove(destination, qos_class, port_id);
        end
        else
        begin
            idx = match_entry(destination, qos_class);
            if (idx < 0 || tbl_count[idx] == 0)
            begin
                r.res = RES_NO_MATCH;
            end
            else
            begin
                key[0] = source_address;
                key[1] = destination;
                key[2] = {24'd0, qos_class};
                key[3] = {1'b0, cep_source};
                key[4] = {1'b0, cep_destination};
                h = flow_hash(key);
                region = int'(h) / (65535 / tbl_count[idx]);
                if (region > tbl_count[idx] - 1)
                begin
                    region = tbl_count[idx] - 1;
                end
                r.port = tbl_ports[idx][region];
            end
        end
        r.empty = 1'b1;
        for (int e = 0; e < ENTRIES; e++)
        begin
            if (tbl_valid[e])
            begin
                r.empty = 1'b0;
            end
        end
        return r;
    endfunction

    assign pending_count = replies_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            replies_due.delete();
            fail_count     <= 0;
            response_count <= 0;
            for (int e = 0; e < ENTRIES; e++)
            begin
                tbl_valid[e] = 1'b0;
                tbl_count[e] = 0;
                tbl_rank[e]  = 0;
            end
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                response_count <= response_count + 1;
                if (replies_due.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected response: status %0d port %h empty %0b",
                                 status, next_port, table_empty);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (status !== want.res || next_port !== want.port ||
                        table_empty !== want.empty)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch: status %0d/%0d port %h/%h empty %0b/%0b (exp/got)",
                                     want.res, status, want.port, next_port,
                                     want.empty, table_empty);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                replies_due.push_back(forward_step());
            end
        end
    end

endmodule

// ----- test/ecmp_forwarding_table_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecmp_forwarding_table_test
// Drives table maintenance and lookup transactions into the forwarding table
// with random idling on both channels; the checker beside the block predicts
// and compares every response.
// ----------------------------------------------------------------------------
module ecmp_forwarding_table_test;
    import eft_pkg::*;

    localparam int ENTRIES   = 16;
    localparam int PORTS     = 8;
    localparam int MAX_CYCLE = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [31:0] destination;
    logic [7:0]  qos_class;
    logic [15:0] port_id;
    logic [31:0] source_address;
    logic [30:0] cep_source;
    logic [30:0] cep_destination;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] next_port;
    logic        table_empty;
    int          fail_count;
    int          pending_count;
    int          response_count;
    int          cycle_count;
    int          lookup_count;
    bit          idle_enable;

    // A small pool of destinations keeps entries matching, so that most adds,
    // removes and lookups reach deep into the table rather than missing.
    logic [31:0] dst_pool [6] = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0A00_0001,
                                  32'hC0A8_0101, 32'h8000_0000, 32'h1234_5678};

    ecmp_forwarding_table #(.ENTRIES(ENTRIES), .PORTS(PORTS)) u_top (.*);

    ecmp_forwarding_table_checker #(.ENTRIES(ENTRIES), .PORTS(PORTS)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // The receiver stalls at random, apart from a quiet stretch in the middle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !idle_enable || ($urandom_range(99) >= 36);
        end
    end

    // Watchdog: a generous ceiling on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Presents one transaction and returns at the edge that accepts it.
    // Valid is only dropped by a random idle gap, or by the caller after the
    // last transaction of a burst.
    task automatic send_request(act_t act, logic [31:0] dst, logic [7:0] qos,
                                logic [15:0] port, logic [31:0] src,
                                logic [30:0] cs, logic [30:0] cd);
        while (idle_enable && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        action          <= act;
        destination     <= dst;
        qos_class       <= qos;
        port_id         <= port;
        source_address  <= src;
        cep_source      <= cs;
        cep_destination <= cd;
        if (act == ACT_LOOKUP)
        begin
            lookup_count++;
        end
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_request();
        int          pick;
        act_t        act;
        logic [31:0] dst;
        logic [7:0]  qos;
        logic [15:0] port;
        pick = $urandom_range(99);
        // Mostly adds and lookups on known destinations; removes, flushes and
        // wild values make up the rest.
        act  = (pick < 40) ? ACT_ADD : (pick < 55) ? ACT_REMOVE
             : (pick < 98) ? ACT_LOOKUP : ACT_FLUSH;
        dst  = ($urandom_range(9) == 0) ? $urandom() : dst_pool[$urandom_range(5)];
        if ($urandom_range(49) == 0)
        begin
            dst = 32'd0;
        end
        qos  = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(2));
        port = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(11));
        send_request(act, dst, qos, port, $urandom(), 31'($urandom()), 31'($urandom()));
    endtask

    initial
    begin
        in_valid        <= 1'b0;
        action          <= ACT_ADD;
        destination     <= '0;
        qos_class       <= '0;
        port_id         <= '0;
        source_address  <= '0;
        cep_source      <= '0;
        cep_destination <= '0;
        cycle_count     = 0;
        lookup_count    = 0;
        idle_enable     = 1'b1;
        rst_n           = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: bad arguments, misses on an empty table, wildcard
        // qos, port list overflow, duplicate ports, extremes of every field.
        send_request(ACT_LOOKUP, 32'h0000_0005, 8'd1, 16'd0, '0, '0, '0);
        send_request(ACT_REMOVE, 32'h0000_0005, 8'd1, 16'd0, '0, '0, '0);
        send_request(ACT_ADD, 32'd0, 8'd0, 16'd1, '0, '0, '0);
        send_request(ACT_ADD, 32'hFFFF_FFFF, 8'd0, 16'hFFFF, '0, '0, '0);
        send_request(ACT_ADD, 32'hFFFF_FFFF, 8'd0, 16'hFFFF, '0, '0, '0);
        for (int p = 0; p < PORTS; p++)
        begin
            send_request(ACT_ADD, 32'hFFFF_FFFF, 8'hFF, 16'(p), '0, '0, '0);
        end
        send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 16'd0, '1, '1, '1);
        send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 8'h00, 16'd0, '0, '0, '0);
        send_request(ACT_REMOVE, 32'hFFFF_FFFF, 8'h07, 16'hFFFF, '0, '0, '0);
        send_request(ACT_REMOVE, 32'hFFFF_FFFF, 8'h07, 16'h1234, '0, '0, '0);
        send_request(ACT_LOOKUP, 32'd0, 8'd0, 16'd0, '0, '0, '0);
        send_request(ACT_FLUSH, 32'd0, 8'd0, 16'd0, '0, '0, '0);
        // Fill the table, then overflow it by one entry.
        for (int e = 0; e <= ENTRIES; e++)
        begin
            send_request(ACT_ADD, 32'(e + 100), 8'd3, 16'hAAAA, '0, '0, '0);
        end
        send_request(ACT_FLUSH, 32'd0, 8'd0, 16'd0, '0, '0, '0);
        in_valid <= 1'b0;
        @(posedge clk);

        // Hold off until the table has answered everything outstanding.
        wait (pending_count == 0);

        for (int n = 0; n < 400; n++)
        begin
            idle_enable = !(n >= 150 && n < 230);
            random_request();
        end
        in_valid <= 1'b0;
        @(posedge clk);

        wait (pending_count == 0);
        repeat (100) @(posedge clk);
        $display("covered %0d responses, %0d of them lookups, over adds, removes and flushes",
                 response_count, lookup_count);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
